// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the execute core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/rv32ie_pkg.sv =====
`timescale 1ns / 1ps
package rv32ie_pkg;

	localparam int XLEN      = 32;
	localparam int REG_COUNT = 32;
	localparam int RegAddrW  = $clog2(REG_COUNT);
	localparam int ShCntW    = $clog2(XLEN);

	// item kinds
	localparam logic [1:0] MODE_INSTR   = 2'd0;
	localparam logic [1:0] MODE_LOAD    = 2'd1;
	localparam logic [1:0] MODE_PRELOAD = 2'd2;

	// configuration register indexes
	localparam logic [0:0] CFG_START_PC  = 1'd0;
	localparam logic [0:0] CFG_STOP_ADDR = 1'd1;

	// opcodes
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_FENCE  = 7'b0001111;

	localparam logic [31:0] W_ECALL  = 32'h0000_0073;
	localparam logic [31:0] W_EBREAK = 32'h0010_0073;

	localparam logic [6:0] F7_BASE   = 7'b0000000;
	localparam logic [6:0] F7_ALT    = 7'b0100000;
	localparam logic [6:0] F7_MULDIV = 7'b0000001;

	// ALU funct3
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch funct3
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// load / store funct3
	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;
	localparam logic [2:0] F3_SW  = 3'd2;

	// M extension funct3
	localparam logic [2:0] F3_MUL    = 3'd0;
	localparam logic [2:0] F3_MULH   = 3'd1;
	localparam logic [2:0] F3_MULHSU = 3'd2;
	localparam logic [2:0] F3_MULHU  = 3'd3;
	localparam logic [2:0] F3_DIV    = 3'd4;
	localparam logic [2:0] F3_DIVU   = 3'd5;
	localparam logic [2:0] F3_REM    = 3'd6;
	localparam logic [2:0] F3_REMU   = 3'd7;

	// shift kinds
	localparam logic [1:0] SH_LEFT  = 2'd0;
	localparam logic [1:0] SH_RIGHT = 2'd1;
	localparam logic [1:0] SH_ARITH = 2'd2;

	typedef struct packed {
		logic            start;
		logic [2:0]      funct3;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic            done;
		logic [XLEN-1:0] result;
	} md_rsp_t;

endpackage

// ===== hw/rtl/rv32ie_muldiv.sv =====
`timescale 1ns / 1ps
module rv32ie_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  rv32ie_pkg::md_req_t req,
	output rv32ie_pkg::md_rsp_t rsp
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_RUN  = 2'd1;
	localparam logic [1:0] M_FIX  = 2'd2;
	localparam logic [1:0] M_DONE = 2'd3;

	localparam int W = rv32ie_pkg::XLEN;

	logic [1:0]                      st_q;
	logic [rv32ie_pkg::ShCntW-1:0]   cnt_q;
	logic [2:0]                      f3_q;
	logic [W-1:0]                    hi_q, lo_q, opnd_q, res_q;
	logic                            neg_a_q, neg_b_q, bnz_q;

	logic         sgn_a, sgn_b, na, nb;
	logic [W-1:0] abs_a, abs_b;
	logic [W:0]   shifted, msum;
	logic [W+1:0] diff;
	logic         fits;

	always_comb begin
		sgn_a = req.funct3 inside {rv32ie_pkg::F3_MULH, rv32ie_pkg::F3_MULHSU,
			rv32ie_pkg::F3_DIV, rv32ie_pkg::F3_REM};
		sgn_b = req.funct3 inside {rv32ie_pkg::F3_MULH, rv32ie_pkg::F3_DIV,
			rv32ie_pkg::F3_REM};
		na    = sgn_a & req.a[W-1];
		nb    = sgn_b & req.b[W-1];
		abs_a = na ? ('0 - req.a) : req.a;
		abs_b = nb ? ('0 - req.b) : req.b;
		// restoring divide step: remainder and next dividend bit
		shifted = {hi_q, lo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, opnd_q};
		fits    = !diff[W+1];
		// shift-add multiply step
		msum    = lo_q[0] ? ({1'b0, hi_q} + {1'b0, opnd_q}) : {1'b0, hi_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
		end else begin
			case (st_q)
				M_IDLE: if (req.start) st_q <= M_RUN;
				M_RUN:  if (cnt_q == '0) st_q <= M_FIX;
				M_FIX:  st_q <= M_DONE;
				M_DONE: st_q <= M_IDLE;
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				if (req.start) begin
					f3_q    <= req.funct3;
					hi_q    <= '0;
					lo_q    <= abs_a;
					opnd_q  <= abs_b;
					neg_a_q <= na;
					neg_b_q <= nb;
					bnz_q   <= (req.b != '0);
					cnt_q   <= '1;
				end
			end
			M_RUN: begin
				cnt_q <= cnt_q - 1'b1;
				if (f3_q[2]) begin
					hi_q <= fits ? diff[W-1:0] : shifted[W-1:0];
					lo_q <= {lo_q[W-2:0], fits};
				end else begin
					hi_q <= msum[W:1];
					lo_q <= {msum[0], lo_q[W-1:1]};
				end
			end
			M_FIX: begin
				case (f3_q)
					rv32ie_pkg::F3_MUL: res_q <= lo_q;
					rv32ie_pkg::F3_MULH, rv32ie_pkg::F3_MULHSU, rv32ie_pkg::F3_MULHU:
						// high word of the product, negated when the operand signs differ
						res_q <= (neg_a_q ^ neg_b_q) ?
							(~hi_q + {{(W-1){1'b0}}, (lo_q == '0)}) : hi_q;
					rv32ie_pkg::F3_DIV, rv32ie_pkg::F3_DIVU:
						res_q <= ((neg_a_q ^ neg_b_q) & bnz_q) ? ('0 - lo_q) : lo_q;
					default:
						res_q <= neg_a_q ? ('0 - hi_q) : hi_q;
				endcase
			end
			default: ;
		endcase
	end

	assign rsp.done   = (st_q == M_DONE);
	assign rsp.result = res_q;

endmodule

// ===== hw/rtl/rv32im_instruction_execute_core.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Handshake          | Payload
// input     | in        | in_valid/in_stall  | mode, instr_word, load_data, reg_index, reg_value
// result    | out       | out_valid/out_stall| next_pc, mem_*, store_data, halted, illegal
// config    | in        | cfg_write          | cfg_index, cfg_data
//
// A transaction passes through accept, execute and result register load.
// Shifts go through the shift register, one bit per cycle;
// MUL/DIV/REM go through the bit-serial multiply/divide unit.
// Reset clears pc, halted, load tracking and the register file valid bits.
// Input is taken again while a result waits; a stalled result holds the core
// in its result step until the output register is free.
`include "assert_macros.svh"
module rv32im_instruction_execute_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] instr_word,
	input  logic [31:0] load_data,
	input  logic [4:0]  reg_index,
	input  logic [31:0] reg_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        mem_valid,
	output logic        mem_write,
	output logic [31:0] mem_address,
	output logic [1:0]  mem_size,
	output logic [31:0] store_data,
	output logic        halted,
	output logic        illegal,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int W  = rv32ie_pkg::XLEN;
	localparam int AW = rv32ie_pkg::RegAddrW;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_MULDIV = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0]   state_q;
	logic [W-1:0] pc_q, stop_q;
	logic         halted_q, ld_pend_q;
	logic [AW-1:0] ld_dest_q;
	logic [2:0]   ld_kind_q;
	logic         out_valid_q;

	// latched transaction
	logic [1:0]   mode_q;
	logic [W-1:0] instr_q, ldata_q, pval_q;
	logic [AW-1:0] pidx_q;

	// register file: one write port, two registered read ports
	logic [W-1:0]         rf_mem [rv32ie_pkg::REG_COUNT];
	logic [rv32ie_pkg::REG_COUNT-1:0] rf_vld_q;
	logic [W-1:0]         rs1_q, rs2_q;
	logic                 rs1_vld_q, rs2_vld_q;
	logic                 rf_we;
	logic [AW-1:0]        rf_waddr;
	logic [W-1:0]         rf_wdata;

	// bit-serial shifter
	logic [W-1:0]                  shf_q;
	logic [rv32ie_pkg::ShCntW-1:0] shf_cnt_q;
	logic [1:0]                    shf_kind_q;

	// output register
	logic [W-1:0] next_pc_q, mem_address_q, store_data_q;
	logic [W-1:0] o_addr_q, o_sdata_q;
	logic         mem_valid_q, mem_write_q, illegal_q;
	logic         o_memv_q, o_memw_q, o_halt_q, o_ill_q;
	logic [1:0]   mem_size_q, o_size_q;

	logic in_accept, exec_run, slot_free, iter_done;

	// decode
	logic [6:0]    op, f7;
	logic [2:0]    f3;
	logic [AW-1:0] rd;
	logic [W-1:0]  a, b, opb, immi, imms, immu, immj, immb, pc4, ld_ext;
	logic          lt_s, lt_u, take;
	logic          ex_we, ex_illegal, ex_halt, ex_memv, ex_memw, ex_load;
	logic          ex_shift, ex_md;
	logic [W-1:0]  ex_wdata, ex_npc, ex_addr, ex_sdata;
	logic [1:0]    ex_size, ex_shkind;
	logic [rv32ie_pkg::ShCntW-1:0] ex_shamt;

	rv32ie_pkg::md_req_t md_req;
	rv32ie_pkg::md_rsp_t md_rsp;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		op   = instr_q[6:0];
		rd   = instr_q[11:7];
		f3   = instr_q[14:12];
		f7   = instr_q[31:25];
		a    = rs1_vld_q ? rs1_q : '0;
		b    = rs2_vld_q ? rs2_q : '0;
		immi = {{20{instr_q[31]}}, instr_q[31:20]};
		imms = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
		immu = {instr_q[31:12], 12'b0};
		immj = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
			instr_q[30:21], 1'b0};
		immb = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
			instr_q[11:8], 1'b0};
		pc4  = pc_q + 32'd4;
		opb  = (op == rv32ie_pkg::OP_IMM) ? immi : b;
		lt_s = $signed(a) < $signed(opb);
		lt_u = a < opb;

		ex_we      = 1'b0;
		ex_wdata   = '0;
		ex_npc     = pc4;
		ex_illegal = 1'b0;
		ex_halt    = 1'b0;
		ex_memv    = 1'b0;
		ex_memw    = 1'b0;
		ex_addr    = '0;
		ex_size    = '0;
		ex_sdata   = '0;
		ex_load    = 1'b0;
		ex_shift   = 1'b0;
		ex_md      = 1'b0;
		ex_shkind  = rv32ie_pkg::SH_LEFT;
		ex_shamt   = (op == rv32ie_pkg::OP_IMM) ? instr_q[24:20] : b[4:0];
		take       = 1'b0;

		case (op)
			rv32ie_pkg::OP_LUI: begin
				ex_we = 1'b1; ex_wdata = immu;
			end
			rv32ie_pkg::OP_AUIPC: begin
				ex_we = 1'b1; ex_wdata = pc_q + immu;
			end
			rv32ie_pkg::OP_IMM, rv32ie_pkg::OP_REG: begin
				if (op == rv32ie_pkg::OP_REG && f7 == rv32ie_pkg::F7_MULDIV) begin
					ex_md = 1'b1;
				end else if (f3 == rv32ie_pkg::F3_SLL || f3 == rv32ie_pkg::F3_SRL) begin
					if (f7 == rv32ie_pkg::F7_BASE) begin
						ex_shift  = 1'b1;
						ex_shkind = (f3 == rv32ie_pkg::F3_SLL) ?
							rv32ie_pkg::SH_LEFT : rv32ie_pkg::SH_RIGHT;
					end else if (f7 == rv32ie_pkg::F7_ALT && f3 == rv32ie_pkg::F3_SRL) begin
						ex_shift  = 1'b1;
						ex_shkind = rv32ie_pkg::SH_ARITH;
					end else begin
						ex_illegal = 1'b1;
					end
				end else if (op == rv32ie_pkg::OP_REG && f7 == rv32ie_pkg::F7_ALT) begin
					if (f3 == rv32ie_pkg::F3_ADD) begin
						ex_we = 1'b1; ex_wdata = a - b;
					end else begin
						ex_illegal = 1'b1;
					end
				end else if (op == rv32ie_pkg::OP_REG && f7 != rv32ie_pkg::F7_BASE) begin
					ex_illegal = 1'b1;
				end else begin
					ex_we = 1'b1;
					case (f3)
						rv32ie_pkg::F3_ADD:  ex_wdata = a + opb;
						rv32ie_pkg::F3_SLT:  ex_wdata = {31'b0, lt_s};
						rv32ie_pkg::F3_SLTU: ex_wdata = {31'b0, lt_u};
						rv32ie_pkg::F3_XOR:  ex_wdata = a ^ opb;
						rv32ie_pkg::F3_OR:   ex_wdata = a | opb;
						default:             ex_wdata = a & opb;
					endcase
				end
			end
			rv32ie_pkg::OP_LOAD: begin
				if (f3 inside {3'd3, 3'd6, 3'd7}) begin
					ex_illegal = 1'b1;
				end else begin
					ex_memv = 1'b1;
					ex_addr = a + immi;
					ex_size = f3[1:0];
					ex_load = 1'b1;
				end
			end
			rv32ie_pkg::OP_STORE: begin
				if (f3 > rv32ie_pkg::F3_SW) begin
					ex_illegal = 1'b1;
				end else begin
					ex_memv  = 1'b1;
					ex_memw  = 1'b1;
					ex_addr  = a + imms;
					ex_size  = f3[1:0];
					ex_sdata = b;
				end
			end
			rv32ie_pkg::OP_JAL: begin
				ex_we = 1'b1; ex_wdata = pc4;
				ex_npc = pc_q + immj;
			end
			rv32ie_pkg::OP_JALR: begin
				if (f3 != 3'd0) begin
					ex_illegal = 1'b1;
				end else begin
					ex_we = 1'b1; ex_wdata = pc4;
					ex_npc = (a + immi) & ~32'd1;
				end
			end
			rv32ie_pkg::OP_BRANCH: begin
				case (f3)
					rv32ie_pkg::F3_BEQ:  take = (a == b);
					rv32ie_pkg::F3_BNE:  take = (a != b);
					rv32ie_pkg::F3_BLT:  take = lt_s;
					rv32ie_pkg::F3_BGE:  take = !lt_s;
					rv32ie_pkg::F3_BLTU: take = lt_u;
					rv32ie_pkg::F3_BGEU: take = !lt_u;
					default:             ex_illegal = 1'b1;
				endcase
				if (take) ex_npc = pc_q + immb;
			end
			rv32ie_pkg::OP_FENCE: begin
				if (f3 != 3'd0) ex_illegal = 1'b1;
			end
			default: begin
				if (instr_q == rv32ie_pkg::W_ECALL || instr_q == rv32ie_pkg::W_EBREAK) begin
					ex_halt = 1'b1;
					ex_npc  = pc_q;
				end else begin
					ex_illegal = 1'b1;
				end
			end
		endcase
		if (ex_illegal) ex_npc = pc4;
	end

	assign exec_run = (mode_q == rv32ie_pkg::MODE_INSTR) && !halted_q && !ld_pend_q &&
		(pc_q != stop_q);
	assign iter_done = (state_q == S_SHIFT && shf_cnt_q == '0) ||
		(state_q == S_MULDIV && md_rsp.done);

	// sign or zero extend the returning load
	always_comb begin
		case (ld_kind_q)
			rv32ie_pkg::F3_LB:  ld_ext = {{24{ldata_q[7]}}, ldata_q[7:0]};
			rv32ie_pkg::F3_LH:  ld_ext = {{16{ldata_q[15]}}, ldata_q[15:0]};
			rv32ie_pkg::F3_LBU: ld_ext = {24'b0, ldata_q[7:0]};
			rv32ie_pkg::F3_LHU: ld_ext = {16'b0, ldata_q[15:0]};
			default:            ld_ext = ldata_q;
		endcase
	end

	// single write port; x0 is never written, so it always reads invalid (zero)
	always_comb begin
		rf_waddr = rd;
		rf_wdata = ex_wdata;
		rf_we    = 1'b0;
		case (state_q)
			S_EXEC: begin
				case (mode_q)
					rv32ie_pkg::MODE_INSTR: rf_we = exec_run && ex_we;
					rv32ie_pkg::MODE_LOAD: begin
						rf_we = ld_pend_q; rf_waddr = ld_dest_q; rf_wdata = ld_ext;
					end
					rv32ie_pkg::MODE_PRELOAD: begin
						rf_we = 1'b1; rf_waddr = pidx_q; rf_wdata = pval_q;
					end
					default: rf_we = 1'b0;
				endcase
			end
			S_SHIFT: begin
				rf_we = iter_done; rf_wdata = shf_q;
			end
			S_MULDIV: begin
				rf_we = iter_done; rf_wdata = md_rsp.result;
			end
			default: rf_we = 1'b0;
		endcase
		if (rf_waddr == '0) rf_we = 1'b0;
	end

	assign md_req.start  = (state_q == S_EXEC) && exec_run && ex_md;
	assign md_req.funct3 = f3;
	assign md_req.a      = a;
	assign md_req.b      = b;

	rv32ie_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			stop_q      <= '0;
			halted_q    <= 1'b0;
			ld_pend_q   <= 1'b0;
			ld_dest_q   <= '0;
			ld_kind_q   <= '0;
			out_valid_q <= 1'b0;
			rf_vld_q    <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					rv32ie_pkg::CFG_START_PC:  pc_q   <= cfg_data;
					rv32ie_pkg::CFG_STOP_ADDR: stop_q <= cfg_data;
					default: ;
				endcase
			end
			// raise valid when a result is loaded, drop it when the result leaves
			if (state_q == S_RESP && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
			case (state_q)
				S_IDLE: if (in_accept) state_q <= S_EXEC;
				S_EXEC: begin
					// halt on arrival at the stop address without executing
					if (mode_q == rv32ie_pkg::MODE_INSTR && !halted_q && !ld_pend_q &&
						pc_q == stop_q)
						halted_q <= 1'b1;
					if (exec_run && !ex_shift && !ex_md) begin
						pc_q <= ex_npc;
						if (ex_halt || ex_npc == stop_q) halted_q <= 1'b1;
						if (ex_load) begin
							ld_pend_q <= 1'b1;
							ld_dest_q <= rd;
							ld_kind_q <= f3;
						end
					end
					if (mode_q == rv32ie_pkg::MODE_LOAD) ld_pend_q <= 1'b0;
					if (exec_run && ex_shift)
						state_q <= S_SHIFT;
					else if (exec_run && ex_md)
						state_q <= S_MULDIV;
					else
						state_q <= S_RESP;
				end
				S_SHIFT, S_MULDIV: begin
					if (iter_done) begin
						pc_q <= pc4;
						if (pc4 == stop_q) halted_q <= 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
		if (in_accept) begin
			mode_q    <= mode;
			instr_q   <= instr_word;
			ldata_q   <= load_data;
			pidx_q    <= reg_index;
			pval_q    <= reg_value;
			rs1_q     <= rf_mem[instr_word[19:15]];
			rs2_q     <= rf_mem[instr_word[24:20]];
			rs1_vld_q <= rf_vld_q[instr_word[19:15]];
			rs2_vld_q <= rf_vld_q[instr_word[24:20]];
		end
		if (state_q == S_EXEC) begin
			mem_valid_q   <= exec_run && ex_memv;
			mem_write_q   <= exec_run && ex_memw;
			mem_address_q <= exec_run ? ex_addr : '0;
			mem_size_q    <= exec_run ? ex_size : '0;
			store_data_q  <= exec_run ? ex_sdata : '0;
			illegal_q     <= exec_run && ex_illegal;
			shf_q         <= a;
			shf_cnt_q     <= ex_shamt;
			shf_kind_q    <= ex_shkind;
		end
		// advance the shifter one bit per cycle
		if (state_q == S_SHIFT && shf_cnt_q != '0) begin
			shf_cnt_q <= shf_cnt_q - 1'b1;
			case (shf_kind_q)
				rv32ie_pkg::SH_LEFT:  shf_q <= {shf_q[W-2:0], 1'b0};
				rv32ie_pkg::SH_ARITH: shf_q <= {shf_q[W-1], shf_q[W-1:1]};
				default:              shf_q <= {1'b0, shf_q[W-1:1]};
			endcase
		end
		// load the output register when the previous result has left
		if (state_q == S_RESP && slot_free) begin
			next_pc_q <= pc_q;
			o_memv_q  <= mem_valid_q;
			o_memw_q  <= mem_write_q;
			o_addr_q  <= mem_address_q;
			o_size_q  <= mem_size_q;
			o_sdata_q <= store_data_q;
			o_halt_q  <= halted_q;
			o_ill_q   <= illegal_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = next_pc_q;
	assign mem_valid   = o_memv_q;
	assign mem_write   = o_memw_q;
	assign mem_address = o_addr_q;
	assign mem_size    = o_size_q;
	assign store_data  = o_sdata_q;
	assign halted      = o_halt_q;
	assign illegal     = o_ill_q;

	`ASSERT_NEXT(a_accept_to_exec, clk, arst_n, in_accept, state_q == S_EXEC)
	`ASSERT_IMPLIES(a_md_done_in_wait, clk, arst_n, md_rsp.done, state_q == S_MULDIV)
	`ASSERT_IMPLIES(a_no_write_idle, clk, arst_n, state_q == S_IDLE, !rf_we)
	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q, halted_q)

endmodule
